/* src/bbr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bbr_pkg;

    localparam int unsigned WORD_W       = 32;
    localparam int unsigned RETRY_W      = 9;
    localparam int unsigned LIMIT_W      = 8;
    localparam int unsigned SHIFT_W      = 4;
    localparam int unsigned CFG_INDEX_W  = 2;
    localparam int unsigned CFG_DATA_W   = 8;

    localparam logic [LIMIT_W-1:0] RETRY_LIMIT_RST = LIMIT_W'(10);
    localparam logic [SHIFT_W-1:0] BLOCK_SHIFT_RST = SHIFT_W'(9);
    localparam logic [RETRY_W-1:0] RETRY_CEILING   = RETRY_W'(257);

    localparam logic [CFG_INDEX_W-1:0] CFG_AUTO_BBR_ENABLE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RETRY_LIMIT     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_SHIFT     = 2'd2;

    localparam logic MODE_START      = 1'b0;
    localparam logic MODE_COMPLETION = 1'b1;

    typedef enum logic [2:0] {
        ACT_DECLINED = 3'd0,
        ACT_REASSIGN = 3'd1,
        ACT_READ     = 3'd2,
        ACT_WRITE    = 3'd3,
        ACT_RESTART  = 3'd4,
        ACT_GIVE_UP  = 3'd5,
        ACT_ERROR    = 3'd6
    } t_action;

    typedef enum logic [4:0] {
        PH_IDLE       = 5'b00001,
        PH_COMPLETE   = 5'b00010,
        PH_RETRY_READ = 5'b00100,
        PH_COPY       = 5'b01000,
        PH_VERIFY     = 5'b10000
    } t_phase;

    typedef struct packed {
        logic              mode;
        logic [WORD_W-1:0] bad_block;
        logic              is_read;
        logic              internal_op;
        logic [WORD_W-1:0] req_record;
        logic [WORD_W-1:0] req_address;
        logic [WORD_W-1:0] req_count;
        logic [WORD_W-1:0] req_residual;
        logic [WORD_W-1:0] partition_offset;
        logic              cmd_success;
    } t_in_item;

    typedef struct packed {
        t_action           action;
        logic [WORD_W-1:0] cmd_block;
        logic [WORD_W-1:0] out_record;
        logic [WORD_W-1:0] out_address;
        logic [WORD_W-1:0] out_count;
        logic              out_is_read;
    } t_out_item;

    typedef struct packed {
        logic               auto_bbr_enable;
        logic [LIMIT_W-1:0] retry_limit;
        logic [SHIFT_W-1:0] block_shift;
    } t_cfg;

endpackage

`default_nettype wire

/* src/bbr_in_reg.sv */
`timescale 1ns / 1ps
`default_nettype none

module bbr_in_reg (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_ready,
    input  bbr_pkg::t_in_item  i_item,
    output logic               o_valid,
    output bbr_pkg::t_in_item  o_item,
    input  wire                i_take
);
    import bbr_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

/* src/bbr_core.sv */
`timescale 1ns / 1ps
`default_nettype none

module bbr_core (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  bbr_pkg::t_cfg      i_cfg,
    input  wire                i_advance,
    input  bbr_pkg::t_in_item  i_item,
    output bbr_pkg::t_out_item o_res
);
    import bbr_pkg::*;

    t_phase              r_phase, n_phase;
    logic [RETRY_W-1:0]  r_retries_done, n_retries_done;
    logic [WORD_W-1:0]   r_saved_bad_block, n_saved_bad_block;
    logic [WORD_W-1:0]   r_saved_record, n_saved_record;
    logic [WORD_W-1:0]   r_saved_address, n_saved_address;
    logic [WORD_W-1:0]   r_saved_count, n_saved_count;
    logic [WORD_W-1:0]   r_saved_residual, n_saved_residual;
    logic [WORD_W-1:0]   r_saved_part_offset, n_saved_part_offset;
    logic [WORD_W-1:0]   r_work_record, n_work_record;
    logic [WORD_W-1:0]   r_work_address, n_work_address;
    logic [WORD_W-1:0]   r_work_count, n_work_count;
    logic                r_work_is_read, n_work_is_read;

    logic [WORD_W-1:0]   rel_block;
    logic [WORD_W-1:0]   rewind_record;
    logic [WORD_W-1:0]   rewind_address;
    logic [WORD_W-1:0]   rewind_count;
    logic [RETRY_W-1:0]  retries_inc;
    logic [RETRY_W-1:0]  limit_ext;
    logic                start_ok;

    assign rel_block      = r_saved_bad_block - r_saved_part_offset;
    assign rewind_record  = r_saved_record - (r_saved_residual >> i_cfg.block_shift);
    assign rewind_address = r_saved_address - r_saved_residual;
    assign rewind_count   = r_saved_count + r_saved_residual;
    assign retries_inc    = r_retries_done + RETRY_W'(1);
    assign limit_ext      = RETRY_W'(i_cfg.retry_limit);
    assign start_ok       = i_cfg.auto_bbr_enable && !i_item.internal_op;

    always_comb begin
        n_phase             = r_phase;
        n_retries_done      = r_retries_done;
        n_saved_bad_block   = r_saved_bad_block;
        n_saved_record      = r_saved_record;
        n_saved_address     = r_saved_address;
        n_saved_count       = r_saved_count;
        n_saved_residual    = r_saved_residual;
        n_saved_part_offset = r_saved_part_offset;
        n_work_record       = r_work_record;
        n_work_address      = r_work_address;
        n_work_count        = r_work_count;
        n_work_is_read      = r_work_is_read;
        o_res               = '0;
        o_res.action        = ACT_DECLINED;

        if (i_item.mode == MODE_START) begin
            if (start_ok) begin
                n_saved_bad_block   = i_item.bad_block;
                n_retries_done      = '0;
                n_saved_record      = i_item.req_record;
                n_saved_address     = i_item.req_address;
                n_saved_count       = i_item.req_count;
                n_saved_residual    = i_item.req_residual;
                n_saved_part_offset = i_item.partition_offset;
                n_work_record       = i_item.req_record;
                n_work_address      = i_item.req_address;
                n_work_count        = i_item.req_count;
                n_work_is_read      = i_item.is_read;
                if (!i_item.is_read) begin
                    n_phase         = PH_COMPLETE;
                    o_res.action    = ACT_REASSIGN;
                    o_res.cmd_block = i_item.bad_block;
                end else begin
                    n_phase           = PH_RETRY_READ;
                    o_res.action      = ACT_READ;
                    o_res.out_record  = i_item.req_record;
                    o_res.out_address = i_item.req_address;
                    o_res.out_count   = i_item.req_count;
                    o_res.out_is_read = 1'b1;
                end
            end
        end else begin
            // finish fields default to the saved request; give up keeps them, restart replaces them with rewound values
            o_res.out_record  = r_saved_record;
            o_res.out_address = r_saved_address;
            o_res.out_count   = r_saved_count;
            o_res.out_is_read = r_work_is_read;
            unique case (r_phase)
                PH_COMPLETE: begin
                    n_phase = PH_IDLE;
                    if (i_item.cmd_success) begin
                        o_res.action      = ACT_RESTART;
                        o_res.out_record  = rewind_record;
                        o_res.out_address = rewind_address;
                        o_res.out_count   = rewind_count;
                    end else begin
                        o_res.action = ACT_GIVE_UP;
                    end
                end
                PH_RETRY_READ: begin
                    if (i_item.cmd_success) begin
                        n_retries_done  = '0;
                        n_phase         = PH_COPY;
                        o_res           = '0;
                        o_res.action    = ACT_REASSIGN;
                        o_res.cmd_block = r_saved_bad_block;
                    end else begin
                        n_retries_done = retries_inc;
                        if (r_retries_done < limit_ext) begin
                            o_res.action      = ACT_READ;
                            o_res.out_record  = r_work_record;
                            o_res.out_address = r_work_address;
                            o_res.out_count   = r_work_count;
                        end else begin
                            n_phase      = PH_IDLE;
                            o_res.action = ACT_GIVE_UP;
                        end
                    end
                end
                PH_COPY: begin
                    if (i_item.cmd_success) begin
                        n_work_address = r_work_address
                            + ((rel_block - r_work_record) << i_cfg.block_shift);
                        n_work_record  = rel_block;
                        n_work_count   = WORD_W'(1) << i_cfg.block_shift;
                        n_work_is_read = 1'b0;
                        n_phase        = PH_VERIFY;
                        o_res.action      = ACT_WRITE;
                        o_res.out_record  = n_work_record;
                        o_res.out_address = n_work_address;
                        o_res.out_count   = n_work_count;
                        o_res.out_is_read = 1'b0;
                    end else begin
                        n_phase      = PH_IDLE;
                        o_res.action = ACT_GIVE_UP;
                    end
                end
                PH_VERIFY: begin
                    if (i_item.cmd_success) begin
                        n_work_is_read    = 1'b1;
                        n_phase           = PH_IDLE;
                        o_res.action      = ACT_RESTART;
                        o_res.out_record  = rewind_record;
                        o_res.out_address = rewind_address;
                        o_res.out_count   = rewind_count;
                        o_res.out_is_read = 1'b1;
                    end else begin
                        n_retries_done = retries_inc;
                        if (r_retries_done > limit_ext) begin
                            n_work_is_read    = 1'b1;
                            n_phase           = PH_IDLE;
                            o_res.action      = ACT_GIVE_UP;
                            o_res.out_is_read = 1'b1;
                        end else begin
                            o_res.action      = ACT_WRITE;
                            o_res.out_record  = r_work_record;
                            o_res.out_address = r_work_address;
                            o_res.out_count   = r_work_count;
                        end
                    end
                end
                default: begin
                    o_res        = '0;
                    o_res.action = ACT_ERROR;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_retries_done <= '0;
        end else if (i_advance) begin
            r_phase        <= n_phase;
            r_retries_done <= n_retries_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_saved_bad_block   <= n_saved_bad_block;
            r_saved_record      <= n_saved_record;
            r_saved_address     <= n_saved_address;
            r_saved_count       <= n_saved_count;
            r_saved_residual    <= n_saved_residual;
            r_saved_part_offset <= n_saved_part_offset;
            r_work_record       <= n_work_record;
            r_work_address      <= n_work_address;
            r_work_count        <= n_work_count;
            r_work_is_read      <= n_work_is_read;
        end
    end

    a_phase_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_phase))
        else $error("phase register lost its one-hot code");

    a_retry_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_retries_done <= RETRY_CEILING)
        else $error("retry count ran past its ceiling");

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && i_item.mode == MODE_START && start_ok
        |=> r_retries_done == '0 && (r_phase == PH_COMPLETE || r_phase == PH_RETRY_READ))
        else $error("accepted start did not set up a fresh recovery");

    a_idle_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && i_item.mode == MODE_COMPLETION && r_phase == PH_IDLE
        |=> r_phase == PH_IDLE && $stable(r_retries_done))
        else $error("completion while idle changed the state");

    a_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && (o_res.action == ACT_RESTART || o_res.action == ACT_GIVE_UP)
        |=> r_phase == PH_IDLE)
        else $error("finish did not return to idle");

endmodule

`default_nettype wire

/* src/bbr_out_reg.sv */
`timescale 1ns / 1ps
`default_nettype none

module bbr_out_reg (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_load,
    output logic               o_space,
    input  bbr_pkg::t_out_item i_item,
    output logic               o_valid,
    input  wire                i_ready,
    output bbr_pkg::t_out_item o_item
);
    import bbr_pkg::*;

    logic      r_valid;
    t_out_item r_item;

    assign o_space = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_space && i_load) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

/* src/bad_block_replacement_sequencer.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel   handshake                  payload
// input     i_in_valid / o_in_ready    i_mode .. i_cmd_success
// result    o_out_valid / i_out_ready  o_action .. o_out_is_read
// config    i_cfg_we                   i_cfg_index, i_cfg_data
//
// one item per cycle unless the result side stalls; each item goes
// through the input register, then the result register with the state update
// synchronous active-low reset clears valids, phase and retry count;
// registers return to enable 1, retry limit 10, block shift 9
// a stalled result register holds the pipe; the input register still
// takes a transfer in the cycle its item moves on

module bad_block_replacement_sequencer (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire [bbr_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire [bbr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire                           i_in_valid,
    output logic                          o_in_ready,
    input  wire                           i_mode,
    input  wire [31:0]                    i_bad_block,
    input  wire                           i_is_read,
    input  wire                           i_internal_op,
    input  wire [31:0]                    i_req_record,
    input  wire [31:0]                    i_req_address,
    input  wire [31:0]                    i_req_count,
    input  wire [31:0]                    i_req_residual,
    input  wire [31:0]                    i_partition_offset,
    input  wire                           i_cmd_success,
    output logic                          o_out_valid,
    input  wire                           i_out_ready,
    output logic [2:0]                    o_action,
    output logic [31:0]                   o_cmd_block,
    output logic [31:0]                   o_out_record,
    output logic [31:0]                   o_out_address,
    output logic [31:0]                   o_out_count,
    output logic                          o_out_is_read
);
    import bbr_pkg::*;

    t_cfg      r_cfg;
    t_in_item  in_item;
    t_in_item  stage_item;
    t_out_item res_item;
    t_out_item out_item;
    logic      stage_valid;
    logic      out_space;
    logic      advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.auto_bbr_enable <= 1'b1;
            r_cfg.retry_limit     <= RETRY_LIMIT_RST;
            r_cfg.block_shift     <= BLOCK_SHIFT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_AUTO_BBR_ENABLE: r_cfg.auto_bbr_enable <= i_cfg_data[0];
                CFG_RETRY_LIMIT:     r_cfg.retry_limit     <= i_cfg_data[LIMIT_W-1:0];
                CFG_BLOCK_SHIFT:     r_cfg.block_shift     <= i_cfg_data[SHIFT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        in_item.mode             = i_mode;
        in_item.bad_block        = i_bad_block;
        in_item.is_read          = i_is_read;
        in_item.internal_op      = i_internal_op;
        in_item.req_record       = i_req_record;
        in_item.req_address      = i_req_address;
        in_item.req_count        = i_req_count;
        in_item.req_residual     = i_req_residual;
        in_item.partition_offset = i_partition_offset;
        in_item.cmd_success      = i_cmd_success;
    end

    assign advance = stage_valid && out_space;

    bbr_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (in_item),
        .o_valid (stage_valid),
        .o_item  (stage_item),
        .i_take  (advance)
    );

    bbr_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_advance (advance),
        .i_item    (stage_item),
        .o_res     (res_item)
    );

    bbr_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (stage_valid),
        .o_space (out_space),
        .i_item  (res_item),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (out_item)
    );

    assign o_action      = out_item.action;
    assign o_cmd_block   = out_item.cmd_block;
    assign o_out_record  = out_item.out_record;
    assign o_out_address = out_item.out_address;
    assign o_out_count   = out_item.out_count;
    assign o_out_is_read = out_item.out_is_read;

endmodule

`default_nettype wire
